// ===== src/gne_pkg.sv =====
package gne_pkg;

   // Command codes carried in the low tuser bit.
   localparam logic CMD_MEASURE = 1'b0;
   localparam logic CMD_ENCODE  = 1'b1;

   // Fixed widths of the peak, its square root and the encoded bytes.
   localparam int PEAK_W = 32;
   localparam int ROOT_W = 16;
   localparam int BYTE_W = 8;

   // Encoded byte values for a zero peak and for a saturated quotient.
   localparam logic [BYTE_W-1:0] ENC_MID  = 8'd127;
   localparam logic [BYTE_W-1:0] ENC_FULL = 8'd255;

   // First test bit of the square root recurrence (highest even power of two).
   localparam logic [PEAK_W-1:0] ROOT_FIRST_BIT = 32'h4000_0000;

   // Result packing: peak in the low word, then x, y and z bytes.
   localparam int RSP_W = PEAK_W + 3 * BYTE_W;

   // Control that the sequencer hands to each component lane.
   typedef struct packed {
      logic       square;  // register the squared magnitude
      logic       prep;    // set up the division or settle a special case
      logic       step;    // one restoring division step
      logic [2:0] idx;     // quotient bit resolved by this step
   } lane_ctrl_type;

endpackage

// ===== src/gne_isqrt.sv =====
module gne_isqrt
   import gne_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PEAK_W-1:0] value,
   output logic [ROOT_W-1:0] root,
   output logic              done
);

   logic [PEAK_W-1:0] x_ff;
   logic [PEAK_W-1:0] res_ff;
   logic [PEAK_W-1:0] bit_ff;
   logic              done_ff;
   logic [PEAK_W-1:0] trial;
   logic              fits;

   // One digit of the root per cycle: test whether the trial value still fits.
   assign trial = res_ff + bit_ff;
   assign fits  = (x_ff >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            x_ff   <= value;
            res_ff <= '0;
            bit_ff <= ROOT_FIRST_BIT;
         end else if (|bit_ff) begin
            if (fits) begin
               x_ff   <= x_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff == PEAK_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // The root of a 32-bit value always fits in the low half.
   assign root = res_ff[ROOT_W-1:0];
   assign done = done_ff;

endmodule

// ===== src/gne_lane.sv =====
module gne_lane
   import gne_pkg::*;
#(
   parameter int GRAD_BITS = 16
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic signed [GRAD_BITS-1:0] grad,
   input  logic [ROOT_W-1:0]           root,
   input  lane_ctrl_type               ctrl,
   output logic [2*GRAD_BITS-1:0]      square,
   output logic [BYTE_W-1:0]           enc
);

   localparam int SUM_W = ((GRAD_BITS > ROOT_W) ? GRAD_BITS : ROOT_W) + 2;
   localparam int NUM_W = SUM_W + 8;
   localparam int REM_W = ROOT_W + 9;
   localparam int SQ_W  = 2 * GRAD_BITS;

   logic [GRAD_BITS-1:0]    grad_u;
   logic [GRAD_BITS-1:0]    mag;
   logic signed [SUM_W-1:0] g_ext;
   logic signed [SUM_W-1:0] m_ext;
   logic signed [SUM_W-1:0] sum;
   logic [SUM_W-1:0]        sum_u;
   logic [NUM_W-1:0]        num;
   logic [NUM_W-1:0]        limit;
   logic [REM_W-1:0]        trial;

   logic [SQ_W-1:0]   sq_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [BYTE_W-1:0] enc_ff;
   logic              div_on_ff;

   // Magnitude of the component; the most negative code maps to its unsigned value.
   assign grad_u = grad;
   assign mag    = grad[GRAD_BITS-1] ? (~grad_u + 1'b1) : grad_u;

   // Numerator 255 * (g + M), formed as a shift and a subtract.
   assign g_ext = SUM_W'(grad);
   assign m_ext = SUM_W'({1'b0, root});
   assign sum   = g_ext + m_ext;
   assign sum_u = sum;
   assign num   = {sum_u, 8'b0} - NUM_W'(sum_u);

   // A quotient of 256 or more against divisor 2M saturates.
   assign limit = NUM_W'({root, 9'b0});
   assign trial = REM_W'({root, 1'b0}) << ctrl.idx;

   always_ff @(posedge clock) begin
      if (ctrl.square) begin
         sq_ff <= SQ_W'(mag) * SQ_W'(mag);
      end
   end

   // Restoring division, one quotient bit per step from the top bit down.
   always_ff @(posedge clock) begin
      if (reset) begin
         div_on_ff <= 1'b0;
      end else if (ctrl.prep) begin
         priority if (root == '0) begin
            enc_ff    <= ENC_MID;
            div_on_ff <= 1'b0;
         end else if (sum < 0) begin
            enc_ff    <= '0;
            div_on_ff <= 1'b0;
         end else if (num >= limit) begin
            enc_ff    <= ENC_FULL;
            div_on_ff <= 1'b0;
         end else begin
            enc_ff    <= '0;
            rem_ff    <= num[REM_W-1:0];
            div_on_ff <= 1'b1;
         end
      end else if (ctrl.step && div_on_ff && (rem_ff >= trial)) begin
         rem_ff           <= rem_ff - trial;
         enc_ff[ctrl.idx] <= 1'b1;
      end
   end

   assign square = sq_ff;
   assign enc    = enc_ff;

endmodule

// ===== src/gne_merge.sv =====
module gne_merge
   import gne_pkg::*;
#(
   parameter int GRAD_BITS = 16
)
(
   input  logic [2*GRAD_BITS-1:0] sq_x,
   input  logic [2*GRAD_BITS-1:0] sq_y,
   input  logic [2*GRAD_BITS-1:0] sq_z,
   input  logic [PEAK_W-1:0]      peak,
   input  logic                   restart,
   input  logic                   command,
   input  logic [BYTE_W-1:0]      enc_x,
   input  logic [BYTE_W-1:0]      enc_y,
   input  logic [BYTE_W-1:0]      enc_z,
   output logic [PEAK_W-1:0]      new_peak,
   output logic [RSP_W-1:0]       rsp_data
);

   localparam int SUM_W = 2 * GRAD_BITS + 2;
   localparam int EXT_W = (SUM_W > PEAK_W) ? SUM_W : PEAK_W + 1;

   logic [SUM_W-1:0]  sum;
   logic [EXT_W-1:0]  sum_ext;
   logic [PEAK_W-1:0] sq32;
   logic [PEAK_W-1:0] base;
   logic              is_encode;

   // Squared magnitude, saturated to the peak width.
   assign sum     = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
   assign sum_ext = EXT_W'(sum);
   assign sq32    = (|sum_ext[EXT_W-1:PEAK_W]) ? '1 : sum_ext[PEAK_W-1:0];

   // Running maximum, optionally restarted from zero.
   assign base     = restart ? '0 : peak;
   assign new_peak = (sq32 > base) ? sq32 : base;

   // Result word: bytes are zero for a measure item.
   assign is_encode = (command == CMD_ENCODE);
   assign rsp_data  = is_encode ? {enc_z, enc_y, enc_x, peak}
                                : {{(3 * BYTE_W){1'b0}}, peak};

endmodule

// ===== src/gradient_normal_encoder.sv =====
// Channel | Ports                         | Fields, lowest bit first
// req     | req_tvalid/tready/tdata/tuser | tdata: grad_x, grad_y, grad_z; tuser: command, restart
// rsp     | rsp_tvalid/tready/tdata       | tdata: peak_square, enc_x, enc_y, enc_z
//
// Measure: capture, squaring, merge and load, then the next item can be taken.
// Encode with a cached root: capture, setup, 8 division steps, load; the first
// encode after any measure item first runs the bit-serial square root.
// Reset clears the peak, the cached root's valid flag and the result valid flag.
// A stalled result holds the sequencer in its output state; the result register still lets
// the next item be taken while a result waits.
module gradient_normal_encoder
   import gne_pkg::*;
#(
   parameter int GRAD_BITS = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // grad_x, grad_y, grad_z, zero padding to whole bytes
   input  logic [((3*GRAD_BITS+7)/8)*8-1:0] req_tdata,
   // command, restart
   input  logic [1:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // peak_square[31:0], enc_x[39:32], enc_y[47:40], enc_z[55:48]
   output logic [RSP_W-1:0]         rsp_tdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_MERGE  = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_PREP   = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   localparam int SQ_W = 2 * GRAD_BITS;

   logic [2:0]                  state_ff;
   logic [2:0]                  state_in;
   logic signed [GRAD_BITS-1:0] gx_ff;
   logic signed [GRAD_BITS-1:0] gy_ff;
   logic signed [GRAD_BITS-1:0] gz_ff;
   logic                        cmd_ff;
   logic                        restart_ff;
   logic [PEAK_W-1:0]           peak_ff;
   logic [PEAK_W-1:0]           peak_in;
   logic [ROOT_W-1:0]           root_ff;
   logic                        root_valid_ff;
   logic [2:0]                  cnt_ff;
   logic                        rsp_valid_ff;
   logic [RSP_W-1:0]            rsp_data_ff;

   logic                        req_xfer;
   logic                        rsp_free;
   logic                        root_start;
   logic [ROOT_W-1:0]           root_new;
   logic                        root_done;
   lane_ctrl_type               lane_ctrl;
   logic [SQ_W-1:0]             sq_x;
   logic [SQ_W-1:0]             sq_y;
   logic [SQ_W-1:0]             sq_z;
   logic [BYTE_W-1:0]           enc_x;
   logic [BYTE_W-1:0]           enc_y;
   logic [BYTE_W-1:0]           enc_z;
   logic [PEAK_W-1:0]           merged_peak;
   logic [RSP_W-1:0]            rsp_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign root_start = req_xfer && (req_tuser[0] == CMD_ENCODE) && !root_valid_ff;

   // Sequencer for one item at a time.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser[0] == CMD_MEASURE) begin
                  state_in = ST_SQUARE;
               end else if (root_valid_ff) begin
                  state_in = ST_PREP;
               end else begin
                  state_in = ST_ROOT;
               end
            end
         end
         ST_SQUARE: state_in = ST_MERGE;
         ST_MERGE:  state_in = ST_OUT;
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP:   state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Lane control for the current state.
   always_comb begin
      lane_ctrl.square = (state_ff == ST_SQUARE);
      lane_ctrl.prep   = (state_ff == ST_PREP);
      lane_ctrl.step   = (state_ff == ST_DIV);
      lane_ctrl.idx    = cnt_ff;
   end

   assign peak_in = (state_ff == ST_MERGE) ? merged_peak : peak_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         peak_ff       <= '0;
         root_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         peak_ff  <= peak_in;
         if (state_ff == ST_MERGE) begin
            root_valid_ff <= 1'b0;
         end else if (root_done) begin
            root_valid_ff <= 1'b1;
         end
         if ((state_ff == ST_OUT) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item capture, cached root, step count and the result register.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         gx_ff      <= req_tdata[GRAD_BITS-1:0];
         gy_ff      <= req_tdata[2*GRAD_BITS-1:GRAD_BITS];
         gz_ff      <= req_tdata[3*GRAD_BITS-1:2*GRAD_BITS];
         cmd_ff     <= req_tuser[0];
         restart_ff <= req_tuser[1];
      end
      if (root_done) begin
         root_ff <= root_new;
      end
      if (state_ff == ST_PREP) begin
         cnt_ff <= 3'(BYTE_W - 1);
      end else if (state_ff == ST_DIV) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
      if ((state_ff == ST_OUT) && rsp_free) begin
         rsp_data_ff <= rsp_data;
      end
   end

   gne_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (peak_ff),
      .root  (root_new),
      .done  (root_done)
   );

   gne_lane #(.GRAD_BITS(GRAD_BITS)) u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .grad   (gx_ff),
      .root   (root_ff),
      .ctrl   (lane_ctrl),
      .square (sq_x),
      .enc    (enc_x)
   );

   gne_lane #(.GRAD_BITS(GRAD_BITS)) u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .grad   (gy_ff),
      .root   (root_ff),
      .ctrl   (lane_ctrl),
      .square (sq_y),
      .enc    (enc_y)
   );

   gne_lane #(.GRAD_BITS(GRAD_BITS)) u_lane_z (
      .clock  (clock),
      .reset  (reset),
      .grad   (gz_ff),
      .root   (root_ff),
      .ctrl   (lane_ctrl),
      .square (sq_z),
      .enc    (enc_z)
   );

   gne_merge #(.GRAD_BITS(GRAD_BITS)) u_merge (
      .sq_x     (sq_x),
      .sq_y     (sq_y),
      .sq_z     (sq_z),
      .peak     (peak_ff),
      .restart  (restart_ff),
      .command  (cmd_ff),
      .enc_x    (enc_x),
      .enc_y    (enc_y),
      .enc_z    (enc_z),
      .new_peak (merged_peak),
      .rsp_data (rsp_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/gne_checker.sv =====
module gne_checker
   import gne_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // A stalled result stays offered with the same data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   // Only one item is in work: after a transfer the input closes.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted a second item while busy");

   // A new result appears only after an item was in work.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared with no item in work");

   // Reset leaves no result on offer.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind gradient_normal_encoder gne_checker u_gne_checker (.*);

// ===== sim/tb_gradient_normal_encoder.sv =====
`timescale 1ns / 1ps

module tb_gradient_normal_encoder;
   import gne_pkg::*;

   localparam int GRAD_BITS   = 16;
   localparam int REQ_W       = ((3*GRAD_BITS+7)/8)*8;
   localparam int TOTAL_ITEMS = 1950;
   localparam int CYCLE_LIMIT = 600000;
   localparam int IDLE_PCT    = 37;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 60;

   // One gradient vector as it goes into the block.
   typedef struct packed {
      logic                        cmd;
      logic                        restart;
      logic signed [GRAD_BITS-1:0] gx;
      logic signed [GRAD_BITS-1:0] gy;
      logic signed [GRAD_BITS-1:0] gz;
   } grad_vector_type;

   // One result as it comes out of the block.
   typedef struct packed {
      logic [PEAK_W-1:0] peak;
      logic [BYTE_W-1:0] ex;
      logic [BYTE_W-1:0] ey;
      logic [BYTE_W-1:0] ez;
   } normal_bytes_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;   // grad_x, grad_y, grad_z
   logic [1:0]        req_tuser = '0;   // command, restart
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;       // peak_square, enc_x, enc_y, enc_z

   grad_vector_type   vector_queue[$];
   normal_bytes_type  expected_normals[$];
   grad_vector_type   vector_on_bus;
   logic [PEAK_W-1:0] peak_level = '0;
   int                vectors_sent = 0;
   int                results_seen = 0;
   int                fail_count = 0;
   int                cycle_count = 0;
   int                hold_left = 0;
   logic              hold_done = 1'b0;

   gradient_normal_encoder #(.GRAD_BITS(GRAD_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Floor square root by setting one bit of the root at a time.
   function automatic longint floor_root(input logic [PEAK_W-1:0] v);
      longint root;
      longint trial;
      root = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root + (longint'(1) << b);
         if (trial * trial <= longint'(v)) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Map a component in [-m, m] onto [0, 255], clamping outside that range.
   function automatic logic [BYTE_W-1:0] component_byte(input longint g, input longint m);
      longint num;
      longint q;
      if (m == 0) begin
         return ENC_MID;
      end
      num = 255 * (g + m);
      if (num < 0) begin
         return '0;
      end
      q = num / (2 * m);
      if (q > 255) begin
         return ENC_FULL;
      end
      return q[BYTE_W-1:0];
   endfunction

   // Advance the peak and work out the result that this vector produces.
   task automatic predict_normal(input grad_vector_type v);
      longint           sq;
      longint           m;
      normal_bytes_type r;
      r = '0;
      if (v.cmd == CMD_MEASURE) begin
         sq = longint'(v.gx) * longint'(v.gx) + longint'(v.gy) * longint'(v.gy)
            + longint'(v.gz) * longint'(v.gz);
         if (sq > 64'h0000_0000_FFFF_FFFF) begin
            sq = 64'h0000_0000_FFFF_FFFF;
         end
         if (v.restart) begin
            peak_level = '0;
         end
         if (sq > longint'(peak_level)) begin
            peak_level = sq[PEAK_W-1:0];
         end
         r.peak = peak_level;
      end else begin
         m = floor_root(peak_level);
         r.peak = peak_level;
         r.ex = component_byte(longint'(v.gx), m);
         r.ey = component_byte(longint'(v.gy), m);
         r.ez = component_byte(longint'(v.gz), m);
      end
      expected_normals.push_back(r);
   endtask

   task automatic queue_vector(input logic cmd, input logic rst, input int x, input int y,
                               input int z);
      grad_vector_type v;
      v.cmd = cmd;
      v.restart = rst;
      v.gx = x[GRAD_BITS-1:0];
      v.gy = y[GRAD_BITS-1:0];
      v.gz = z[GRAD_BITS-1:0];
      vector_queue.push_back(v);
   endtask

   function automatic int rand_comp(input int a);
      return int'($urandom_range(0, 2 * a)) - a;
   endfunction

   // Driver: record each transfer in the predictor, then offer the next vector.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_normal(vector_on_bus);
            vectors_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (vector_queue.size() > 0 &&
                ((vectors_sent >= 300 && vectors_sent < 600) ||
                 $urandom_range(0, 99) >= IDLE_PCT)) begin
               vector_on_bus = vector_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_W'({vector_on_bus.gz, vector_on_bus.gy, vector_on_bus.gx});
               req_tuser <= {vector_on_bus.restart, vector_on_bus.cmd};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, a clean stretch, and one long hold-off that
   // lets the block back up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 1000) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (results_seen >= 300 && results_seen < 600) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Monitor: compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      normal_bytes_type want;
      normal_bytes_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         got.peak = rsp_tdata[PEAK_W-1:0];
         got.ex = rsp_tdata[PEAK_W +: BYTE_W];
         got.ey = rsp_tdata[PEAK_W + BYTE_W +: BYTE_W];
         got.ez = rsp_tdata[PEAK_W + 2*BYTE_W +: BYTE_W];
         if (expected_normals.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_normals.pop_front();
            if (got.peak !== want.peak) begin
               $display("%0t: peak_square expected %0d actual %0d", $time, want.peak, got.peak);
               fail_count++;
            end
            if (got.ex !== want.ex) begin
               $display("%0t: enc_x expected %0d actual %0d", $time, want.ex, got.ex);
               fail_count++;
            end
            if (got.ey !== want.ey) begin
               $display("%0t: enc_y expected %0d actual %0d", $time, want.ey, got.ey);
               fail_count++;
            end
            if (got.ez !== want.ez) begin
               $display("%0t: enc_z expected %0d actual %0d", $time, want.ez, got.ez);
               fail_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int amp;
      int n_meas;
      int n_enc;

      // Directed: encode on a zero peak, restart ignored on encode.
      queue_vector(CMD_ENCODE, 1'b0, 0, 0, 0);
      queue_vector(CMD_ENCODE, 1'b1, 32767, -32768, 5);
      queue_vector(CMD_MEASURE, 1'b1, 0, 0, 0);
      queue_vector(CMD_ENCODE, 1'b0, -1, 1, 0);
      // Largest possible magnitude and encodes at the component extremes.
      queue_vector(CMD_MEASURE, 1'b0, -32768, -32768, -32768);
      queue_vector(CMD_ENCODE, 1'b0, 32767, -32768, 0);
      queue_vector(CMD_ENCODE, 1'b0, -1, 1, -16384);
      // Restart to a small peak, then components beyond it clamp.
      queue_vector(CMD_MEASURE, 1'b1, 3, 4, 0);
      queue_vector(CMD_ENCODE, 1'b0, 5, -5, 0);
      queue_vector(CMD_ENCODE, 1'b0, 32767, -32768, 6);
      queue_vector(CMD_ENCODE, 1'b1, 2, -2, 1);
      // A smaller vector leaves the peak alone, a larger one raises it.
      queue_vector(CMD_MEASURE, 1'b0, 1, 1, 1);
      queue_vector(CMD_MEASURE, 1'b0, 32767, 0, 0);
      queue_vector(CMD_ENCODE, 1'b0, 32767, -32767, 0);
      // Peak of one gives a root of one.
      queue_vector(CMD_MEASURE, 1'b1, -1, 0, 0);
      queue_vector(CMD_ENCODE, 1'b0, 1, -1, 0);
      queue_vector(CMD_MEASURE, 1'b1, 32767, 32767, 32767);
      queue_vector(CMD_ENCODE, 1'b0, -32767, 32767, -1);
      queue_vector(CMD_MEASURE, 1'b1, 0, 2, 0);
      queue_vector(CMD_ENCODE, 1'b0, -2, 2, 1);

      // Random: mostly measure-then-encode frames, some raw noise.
      while (vector_queue.size() < TOTAL_ITEMS) begin
         if ($urandom_range(0, 99) < 75) begin
            case ($urandom_range(0, 3))
               0: amp = $urandom_range(0, 15);
               1: amp = $urandom_range(16, 255);
               2: amp = $urandom_range(256, 4095);
               default: amp = 32767;
            endcase
            n_meas = $urandom_range(1, 6);
            n_enc = $urandom_range(1, 8);
            for (int i = 0; i < n_meas; i++) begin
               queue_vector(CMD_MEASURE, i == 0, rand_comp(amp), rand_comp(amp),
                            rand_comp(amp));
            end
            for (int i = 0; i < n_enc; i++) begin
               queue_vector(CMD_ENCODE, $urandom_range(0, 9) == 0, rand_comp(amp),
                            rand_comp(amp), rand_comp(amp));
            end
         end else begin
            n_meas = $urandom_range(1, 4);
            for (int i = 0; i < n_meas; i++) begin
               queue_vector(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535));
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for every vector to go out and every result to come back.
      @(negedge clock);
      while (vector_queue.size() > 0 || req_tvalid || expected_normals.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
